>>> rtl/eohp_pkg.sv
package eohp_pkg;

  localparam int COEF_W = 64;
  localparam int IDX_W  = 5;
  localparam int TIME_W = 49;
  localparam int OUT_W  = 48;
  localparam int K_W    = 5;

  // table layout
  localparam logic [IDX_W-1:0] SLOT_EPOCH_XY = 5'd0;
  localparam logic [IDX_W-1:0] SLOT_EPOCH_UT = 5'd1;
  localparam logic [IDX_W-1:0] SLOT_OFFSET   = 5'd2;
  localparam logic [IDX_W-1:0] SLOT_RATE     = 5'd5;
  localparam logic [IDX_W-1:0] SLOT_AMP      = 5'd8;
  localparam logic [IDX_W-1:0] SLOT_PERIOD   = 5'd24;

  // series select
  localparam logic [1:0] SER_X  = 2'd0;
  localparam logic [1:0] SER_Y  = 2'd1;
  localparam logic [1:0] SER_UT = 2'd2;

  localparam logic [63:0] HALF_PI_62 = 64'h6487ED5110B4611A;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DT,
    OP_ACC_INIT,
    OP_MUL_RATE,
    OP_ADD_RATE,
    OP_PER,
    OP_ERR,
    OP_DIV_PHASE,
    OP_PHASE,
    OP_MUL_X,
    OP_X,
    OP_MUL_XX,
    OP_X2,
    OP_MUL_ST,
    OP_DIV_ST,
    OP_ST,
    OP_MUL_CT,
    OP_DIV_CT,
    OP_CT,
    OP_UNFOLD,
    OP_MUL_SA,
    OP_HT_SET,
    OP_MUL_CA,
    OP_HT_ADD,
    OP_ACC_HT,
    OP_SAT,
    OP_SEND
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] addr;
    logic [K_W-1:0]   k;
    logic [1:0]       ser;
  } ctl_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic per_zero;
    logic out_free;
  } ctl_stat_t;

endpackage

>>> rtl/eohp_ram.sv
module eohp_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/eohp_ctrl.sv
module eohp_ctrl #(
  parameter int SINE_ITERATIONS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  eohp_pkg::ctl_stat_t stat_i,
  output eohp_pkg::ctl_cmd_t  cmd_o,
  output logic                busy_o
);
  import eohp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_EP, ST_DT, ST_ACC, ST_MUL_RATE, ST_W_RATE,
    ST_RD_PER, ST_PER, ST_CHK, ST_W_PH, ST_MUL_X, ST_W_X, ST_MUL_XX, ST_W_XX,
    ST_MUL_ST, ST_W_MST, ST_W_DST, ST_MUL_CT, ST_W_MCT, ST_W_DCT,
    ST_UNFOLD, ST_MUL_SA, ST_W_SA, ST_MUL_CA, ST_W_CA, ST_ADD_HT,
    ST_NEXT_H, ST_SAT, ST_SEND
  } state_e;

  localparam logic [K_W-1:0] K_LAST = K_W'(SINE_ITERATIONS - 1);

  state_e         state_q, state_d;
  logic [1:0]     ser_q, ser_d;
  logic [2:0]     h_q, h_d;
  logic [K_W-1:0] k_q, k_d;
  logic [2:0]     h_last;

  assign h_last = (ser_q == SER_UT) ? 3'd7 : {1'b0, ser_q[0], 1'b1};
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    ser_d      = ser_q;
    h_d        = h_q;
    k_d        = k_q;
    cmd_o.op   = OP_NONE;
    cmd_o.addr = '0;
    cmd_o.k    = k_q;
    cmd_o.ser  = ser_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ser_d   = SER_X;
          state_d = ST_RD_EP;
        end
      end
      ST_RD_EP: begin
        cmd_o.addr = (ser_q == SER_UT) ? SLOT_EPOCH_UT : SLOT_EPOCH_XY;
        state_d    = ST_DT;
      end
      ST_DT: begin
        cmd_o.op   = OP_DT;
        cmd_o.addr = SLOT_OFFSET + IDX_W'(ser_q);
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op   = OP_ACC_INIT;
        cmd_o.addr = SLOT_RATE + IDX_W'(ser_q);
        state_d    = ST_MUL_RATE;
      end
      ST_MUL_RATE: begin
        cmd_o.op = OP_MUL_RATE;
        state_d  = ST_W_RATE;
      end
      ST_W_RATE: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_ADD_RATE;
          h_d      = {ser_q, 1'b0};
          state_d  = ST_RD_PER;
        end
      end
      ST_RD_PER: begin
        cmd_o.addr = SLOT_PERIOD + IDX_W'(h_q);
        state_d    = ST_PER;
      end
      ST_PER: begin
        cmd_o.op = OP_PER;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        if (stat_i.per_zero) begin
          cmd_o.op = OP_ERR;
          state_d  = ST_NEXT_H;
        end else begin
          cmd_o.op = OP_DIV_PHASE;
          state_d  = ST_W_PH;
        end
      end
      ST_W_PH: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_PHASE;
          state_d  = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd_o.op = OP_MUL_X;
        state_d  = ST_W_X;
      end
      ST_W_X: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_X;
          state_d  = ST_MUL_XX;
        end
      end
      ST_MUL_XX: begin
        cmd_o.op = OP_MUL_XX;
        state_d  = ST_W_XX;
      end
      ST_W_XX: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_X2;
          k_d      = K_W'(1);
          state_d  = ST_MUL_ST;
        end
      end
      ST_MUL_ST: begin
        cmd_o.op = OP_MUL_ST;
        state_d  = ST_W_MST;
      end
      ST_W_MST: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_DIV_ST;
          state_d  = ST_W_DST;
        end
      end
      ST_W_DST: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ST;
          state_d  = ST_MUL_CT;
        end
      end
      ST_MUL_CT: begin
        cmd_o.op = OP_MUL_CT;
        state_d  = ST_W_MCT;
      end
      ST_W_MCT: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_DIV_CT;
          state_d  = ST_W_DCT;
        end
      end
      ST_W_DCT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_CT;
          if (k_q == K_LAST) begin
            state_d = ST_UNFOLD;
          end else begin
            k_d     = k_q + K_W'(1);
            state_d = ST_MUL_ST;
          end
        end
      end
      ST_UNFOLD: begin
        cmd_o.op   = OP_UNFOLD;
        cmd_o.addr = SLOT_AMP + IDX_W'({h_q, 1'b0});
        state_d    = ST_MUL_SA;
      end
      ST_MUL_SA: begin
        cmd_o.op = OP_MUL_SA;
        state_d  = ST_W_SA;
      end
      ST_W_SA: begin
        cmd_o.addr = SLOT_AMP + IDX_W'({h_q, 1'b1});
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_HT_SET;
          state_d  = ST_MUL_CA;
        end
      end
      ST_MUL_CA: begin
        cmd_o.op = OP_MUL_CA;
        state_d  = ST_W_CA;
      end
      ST_W_CA: begin
        if (!stat_i.mul_busy) begin
          cmd_o.op = OP_HT_ADD;
          state_d  = ST_ADD_HT;
        end
      end
      ST_ADD_HT: begin
        cmd_o.op = OP_ACC_HT;
        state_d  = ST_NEXT_H;
      end
      ST_NEXT_H: begin
        if (h_q == h_last) begin
          state_d = ST_SAT;
        end else begin
          h_d     = h_q + 3'd1;
          state_d = ST_RD_PER;
        end
      end
      ST_SAT: begin
        cmd_o.op = OP_SAT;
        if (ser_q == SER_UT) begin
          state_d = ST_SEND;
        end else begin
          ser_d   = ser_q + 2'd1;
          state_d = ST_RD_EP;
        end
      end
      ST_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_SEND;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ser_q   <= SER_X;
      h_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ser_q   <= ser_d;
      h_q     <= h_d;
      k_q     <= k_d;
    end
  end

endmodule

>>> rtl/eohp_dp.sv
module eohp_dp #(
  parameter int FRACTION_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [eohp_pkg::TIME_W-1:0]         eval_time_i,
  input  eohp_pkg::ctl_cmd_t                  cmd_i,
  input  logic [eohp_pkg::COEF_W-1:0]         rdata_i,
  output eohp_pkg::ctl_stat_t                 stat_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [eohp_pkg::OUT_W-1:0]   polar_x_o,
  output logic signed [eohp_pkg::OUT_W-1:0]   polar_y_o,
  output logic signed [eohp_pkg::OUT_W-1:0]   ut1_minus_utc_o,
  output logic                                period_error_o
);
  import eohp_pkg::*;

  localparam int FB    = FRACTION_BITS;
  localparam int CNT_W = $clog2(64 + FB + 1);
  localparam logic [CNT_W-1:0] STEPS_PH  = CNT_W'(64 + FB);
  localparam logic [CNT_W-1:0] STEPS_DIV = CNT_W'(64);
  localparam logic [63:0] ONE_62 = 64'h4000000000000000;
  localparam logic [63:0] S64_MAX = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] S64_MIN = 64'h8000000000000000;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // rounded product, ties away from zero, saturated
  function automatic logic [63:0] smul_fin(input logic [127:0] prod, input int sh,
                                           input logic neg);
    logic [127:0] pr;
    logic [63:0]  r;
    logic         ovf;
    pr  = prod + (128'd1 << (sh - 1));
    r   = 64'(pr >> sh);
    ovf = |(pr >> (sh + 64));
    if (neg) return (ovf || r[63]) ? S64_MIN : (64'd0 - r);
    return (ovf || r[63]) ? S64_MAX : r;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input logic [63:0] a);
    if (&a[63:OUT_W-1] || ~|a[63:OUT_W-1]) return a[OUT_W-1:0];
    return a[63] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
  endfunction

  logic [TIME_W-1:0] t_q;
  logic [63:0] dt_q, acc_q, per_q, hterm_q;
  logic [63:0] x_q, x2_q, st_q, ct_q, ss_q, cs_q, s_q, c_q;
  logic [FB-1:0] ph_q;
  logic err_q;
  logic [OUT_W-1:0] res_q [3];
  logic [OUT_W-1:0] out_x_q, out_y_q, out_u_q;
  logic out_err_q, out_valid_q;

  // iterative multiplier, one 32x32 partial product per cycle
  logic [63:0]  ma_q, mb_q;
  logic [127:0] prod_q;
  logic [1:0]   mcnt_q;
  logic         mbusy_q, mneg_q;
  // restoring divider, one quotient bit per cycle
  logic [63:0]  num_q, den_q, rem_q, quo_q;
  logic [CNT_W-1:0] dcnt_q;
  logic         dbusy_q, phneg_q;

  logic [63:0]  mul_a, mul_b;
  logic         mul_n, mul_go, div_go;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  dr;
  logic         dge;
  logic [63:0]  div_num, div_den;
  logic [CNT_W-1:0] div_steps;

  logic [1:0]   quad;
  logic         half;
  logic [59:0]  frac_turn;
  logic [60:0]  u;
  logic [63:0]  ss_u, cs_u, sv, cv, s_c, c_c;
  logic [5:0]   k2;
  logic [11:0]  fs, fc;
  logic [FB-1:0] qf, ph_c;
  logic [64:0]  dts;
  logic [63:0]  dt_c, trunc62, trunc60;

  // phase folding
  assign quad      = ph_q[FB-1:FB-2];
  assign frac_turn = {ph_q[FB-3:0], {(62 - FB){1'b0}}};
  assign half      = frac_turn[59];
  assign u         = half ? ((61'd1 << 60) - 61'(frac_turn)) : 61'(frac_turn);

  assign ss_u = half ? cs_q : ss_q;
  assign cs_u = half ? ss_q : cs_q;
  assign sv   = {1'b0, ss_u[62:0]};
  assign cv   = {1'b0, cs_u[62:0]};

  always_comb begin
    case (quad)
      2'd0:    begin s_c = sv;          c_c = cv;          end
      2'd1:    begin s_c = cv;          c_c = 64'd0 - sv;  end
      2'd2:    begin s_c = 64'd0 - sv;  c_c = 64'd0 - cv;  end
      default: begin s_c = 64'd0 - cv;  c_c = sv;          end
    endcase
  end

  // factorial factors of the next series term
  assign k2 = {cmd_i.k, 1'b0};
  assign fs = 12'(k2) * 12'({cmd_i.k, 1'b1});
  assign fc = 12'(k2) * 12'(k2 - 6'd1);

  assign qf   = quo_q[FB-1:0];
  assign ph_c = phneg_q ? (FB'(0) - qf) : qf;

  assign dts  = {16'd0, t_q} - {rdata_i[63], rdata_i};
  assign dt_c = (dts[64] != dts[63]) ? (dts[64] ? S64_MIN : S64_MAX) : dts[63:0];

  assign trunc62 = 64'(prod_q >> 62);
  assign trunc60 = 64'(prod_q >> 60);

  always_comb begin
    mul_go = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    mul_n  = 1'b0;
    case (cmd_i.op)
      OP_MUL_RATE: begin
        mul_a = mag(rdata_i); mul_b = mag(dt_q); mul_n = rdata_i[63] ^ dt_q[63];
      end
      OP_MUL_X:  begin mul_a = 64'(u);  mul_b = HALF_PI_62; end
      OP_MUL_XX: begin mul_a = x_q;     mul_b = x_q;        end
      OP_MUL_ST: begin mul_a = st_q;    mul_b = x2_q;       end
      OP_MUL_CT: begin mul_a = ct_q;    mul_b = x2_q;       end
      OP_MUL_SA: begin
        mul_a = mag(rdata_i); mul_b = mag(s_q); mul_n = rdata_i[63] ^ s_q[63];
      end
      OP_MUL_CA: begin
        mul_a = mag(rdata_i); mul_b = mag(c_q); mul_n = rdata_i[63] ^ c_q[63];
      end
      default: mul_go = 1'b0;
    endcase
  end

  always_comb begin
    div_go    = 1'b1;
    div_num   = '0;
    div_den   = '0;
    div_steps = STEPS_DIV;
    case (cmd_i.op)
      OP_DIV_PHASE: begin
        div_num = mag(dt_q); div_den = mag(per_q); div_steps = STEPS_PH;
      end
      OP_DIV_ST: begin div_num = trunc62; div_den = 64'(fs); end
      OP_DIV_CT: begin div_num = trunc62; div_den = 64'(fc); end
      default:   div_go = 1'b0;
    endcase
  end

  assign pa = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp = 64'(pa) * 64'(pb);

  always_comb begin
    case (mcnt_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
  end

  assign dr  = {rem_q, num_q[63]};
  assign dge = (dr >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q     <= 1'b0;
      mcnt_q      <= '0;
      dbusy_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_go) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) mbusy_q <= 1'b0;
      end
      if (div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= div_steps;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q - CNT_W'(1);
        if (dcnt_q == CNT_W'(1)) dbusy_q <= 1'b0;
      end
      if (cmd_i.op == OP_SEND) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      ma_q   <= mul_a;
      mb_q   <= mul_b;
      mneg_q <= mul_n;
      prod_q <= '0;
    end else if (mbusy_q) begin
      prod_q <= prod_q + pp_sh;
    end

    if (div_go) begin
      num_q <= div_num;
      den_q <= div_den;
      rem_q <= '0;
      quo_q <= '0;
      if (cmd_i.op == OP_DIV_PHASE) phneg_q <= dt_q[63] ^ per_q[63];
    end else if (dbusy_q) begin
      rem_q <= dge ? 64'(dr - {1'b0, den_q}) : dr[63:0];
      quo_q <= {quo_q[62:0], dge};
      num_q <= {num_q[62:0], 1'b0};
    end

    if (start_i) begin
      t_q   <= eval_time_i;
      err_q <= 1'b0;
    end else if (cmd_i.op == OP_ERR) begin
      err_q <= 1'b1;
    end

    case (cmd_i.op)
      OP_DT:       dt_q  <= dt_c;
      OP_ACC_INIT: acc_q <= rdata_i;
      OP_ADD_RATE: acc_q <= sat_add(acc_q, smul_fin(prod_q, FB, mneg_q));
      OP_PER:      per_q <= rdata_i;
      OP_PHASE:    ph_q  <= ph_c;
      OP_X:        x_q   <= trunc60;
      OP_X2: begin
        x2_q <= trunc62;
        st_q <= x_q;
        ss_q <= x_q;
        ct_q <= ONE_62;
        cs_q <= ONE_62;
      end
      OP_ST: begin
        st_q <= quo_q;
        ss_q <= cmd_i.k[0] ? (ss_q - quo_q) : (ss_q + quo_q);
      end
      OP_CT: begin
        ct_q <= quo_q;
        cs_q <= cmd_i.k[0] ? (cs_q - quo_q) : (cs_q + quo_q);
      end
      OP_UNFOLD: begin
        s_q <= s_c;
        c_q <= c_c;
      end
      OP_HT_SET:   hterm_q <= smul_fin(prod_q, 62, mneg_q);
      OP_HT_ADD:   hterm_q <= sat_add(hterm_q, smul_fin(prod_q, 62, mneg_q));
      OP_ACC_HT:   acc_q   <= sat_add(acc_q, hterm_q);
      OP_SAT:      res_q[cmd_i.ser] <= sat48(acc_q);
      OP_SEND: begin
        out_x_q   <= res_q[SER_X];
        out_y_q   <= res_q[SER_Y];
        out_u_q   <= res_q[SER_UT];
        out_err_q <= err_q;
      end
      default: ;
    endcase
  end

  assign stat_o.mul_busy = mbusy_q;
  assign stat_o.div_busy = dbusy_q;
  assign stat_o.per_zero = (per_q == 64'd0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign polar_x_o       = out_x_q;
  assign polar_y_o       = out_y_q;
  assign ut1_minus_utc_o = out_u_q;
  assign period_error_o  = out_err_q;

endmodule

>>> rtl/earth_orientation_harmonic_predictor_core.sv
// channel  dir  handshake                 beat contents
// in       in   in_valid_i / in_stall_o   req_type, coef_index, coef_value, eval_time
// out      out  out_valid_o / out_stall_i polar_x, polar_y, ut1_minus_utc, period_error
//
// a load beat writes the table and leaves the port ready.
// an evaluate beat runs eight harmonics on one shared iterative multiplier and one
// radix-2 divider; the sine/cosine series dominates the evaluation time.
// reset is asynchronous, the table is undefined until loaded; the finished result
// waits in an output register, so a stalled out side still lets new beats in.
module earth_orientation_harmonic_predictor_core #(
  parameter int FRACTION_BITS   = 32,
  parameter int SINE_ITERATIONS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [eohp_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [eohp_pkg::COEF_W-1:0]  coef_value_i,
  input  logic [eohp_pkg::TIME_W-1:0]         eval_time_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [eohp_pkg::OUT_W-1:0]   polar_x_o,
  output logic signed [eohp_pkg::OUT_W-1:0]   polar_y_o,
  output logic signed [eohp_pkg::OUT_W-1:0]   ut1_minus_utc_o,
  output logic                                period_error_o
);
  import eohp_pkg::*;

  ctl_cmd_t          cmd;
  ctl_stat_t         stat;
  logic              busy, accept, start, load;
  logic [COEF_W-1:0] rdata;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign start      = accept && req_type_i;
  assign load       = accept && !req_type_i;

  eohp_ram #(
    .Width(COEF_W),
    .Depth(32)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (load),
    .waddr_i(coef_index_i),
    .wdata_i(coef_value_i),
    .raddr_i(cmd.addr),
    .rdata_o(rdata)
  );

  eohp_ctrl #(
    .SINE_ITERATIONS(SINE_ITERATIONS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  eohp_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .eval_time_i    (eval_time_i),
    .cmd_i          (cmd),
    .rdata_i        (rdata),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .polar_x_o      (polar_x_o),
    .polar_y_o      (polar_y_o),
    .ut1_minus_utc_o(ut1_minus_utc_o),
    .period_error_o (period_error_o)
  );

endmodule

>>> rtl/eohp_chk.sv
module eohp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        req_type_i,
  input logic [4:0]  coef_index_i,
  input logic [63:0] coef_value_i,
  input logic [48:0] eval_time_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] polar_x_o,
  input logic [47:0] polar_y_o,
  input logic [47:0] ut1_minus_utc_o,
  input logic        period_error_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(polar_x_o) &&
      $stable(polar_y_o) && $stable(ut1_minus_utc_o) && $stable(period_error_o))
    else $error("stalled result changed");

  // an evaluate beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i |=> in_stall_o)
    else $error("evaluate did not start");

  // a load beat leaves the port ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !req_type_i |=> !in_stall_o)
    else $error("load stalled the port");

  // a new result only comes out of a running evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_stall_o))
    else $error("result without evaluation");

endmodule

bind earth_orientation_harmonic_predictor_core eohp_chk u_eohp_chk (.*);

>>> tb/tb_earth_orientation_harmonic_predictor_core.sv
module tb_earth_orientation_harmonic_predictor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import eohp_pkg::*;

  localparam int FRAC_BITS = 32;
  localparam int TERMS     = 24;
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam longint O48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint O48_MIN = -64'sh0000_8000_0000_0000;
  localparam longint MJD_NOW = 64'd60000 << 32;

  typedef struct {
    logic              req_type;
    logic [IDX_W-1:0]  coef_index;
    logic [COEF_W-1:0] coef_value;
    logic [TIME_W-1:0] eval_time;
  } req_t;

  typedef struct {
    logic [OUT_W-1:0] px;
    logic [OUT_W-1:0] py;
    logic [OUT_W-1:0] ut;
    logic             perr;
  } eop_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [IDX_W-1:0] coef_index = '0;
  logic signed [COEF_W-1:0] coef_value = '0;
  logic [TIME_W-1:0] eval_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] polar_x, polar_y, ut1_minus_utc;
  logic period_error;

  req_t pending_reqs[$];
  eop_t expected_eop[$];
  logic [63:0] coef_table[32];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int errors = 0;

  earth_orientation_harmonic_predictor_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .coef_index_i(coef_index),
    .coef_value_i(coef_value), .eval_time_i(eval_time),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .polar_x_o(polar_x), .polar_y_o(polar_y),
    .ut1_minus_utc_o(ut1_minus_utc), .period_error_o(period_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // 128-bit product shifted right, optional round half up on the magnitude
  function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int sh,
                                             bit rnd, output bit ovf);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (rnd) p = p + (128'd1 << (sh - 1));
    ovf = (p[127:64] >> sh) != 0;
    return 64'(p >> sh);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64_MAX)) return I64_MAX;
    if (s < 65'(I64_MIN)) return I64_MIN;
    return 64'(s);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(I64_MAX)) return I64_MAX;
    if (s < 65'(I64_MIN)) return I64_MIN;
    return 64'(s);
  endfunction

  function automatic longint fix_mul(longint a, longint b, int sh);
    bit ovf;
    logic [63:0] ma, mb, r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = prod_shift(ma, mb, sh, 1'b1, ovf);
    if ((a < 0) != (b < 0)) begin
      if (ovf || r[63]) return I64_MIN;
      return -longint'(r);
    end
    if (ovf || r[63]) return I64_MAX;
    return longint'(r);
  endfunction

  function automatic logic [63:0] phase_turns(longint dt, longint per);
    logic [63:0] a, b, rem, q;
    bit carry;
    a = dt < 0 ? -dt : dt;
    b = per < 0 ? -per : per;
    rem = a % b;
    q = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      carry = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (carry || rem >= b) begin
        rem = rem - b;
        q[0] = 1'b1;
      end
    end
    if ((dt < 0) != (per < 0)) q = -q;
    return q & ((64'd1 << FRAC_BITS) - 1);
  endfunction

  task automatic sine_cosine(logic [63:0] ph, output longint so, output longint co);
    bit ovf, half;
    logic [63:0] p62, frac_turn, u, x, x2, st, ss, ct, cs, tmp;
    logic [1:0] quad;
    longint s, c;
    p62 = ph << (62 - FRAC_BITS);
    quad = p62[61:60];
    frac_turn = p62 & ((64'd1 << 60) - 1);
    half = frac_turn[59];
    u = half ? (64'd1 << 60) - frac_turn : frac_turn;
    x = prod_shift(u, HALF_PI_62, 60, 1'b0, ovf);
    x2 = prod_shift(x, x, 62, 1'b0, ovf);
    st = x; ss = x; ct = 64'd1 << 62; cs = 64'd1 << 62;
    for (int k = 1; k < TERMS; k++) begin
      st = prod_shift(st, x2, 62, 1'b0, ovf) / 64'((2 * k) * (2 * k + 1));
      ct = prod_shift(ct, x2, 62, 1'b0, ovf) / 64'((2 * k - 1) * (2 * k));
      if (k & 1) begin
        ss = ss - st; cs = cs - ct;
      end else begin
        ss = ss + st; cs = cs + ct;
      end
    end
    if (half) begin
      tmp = ss; ss = cs; cs = tmp;
    end
    s = {1'b0, ss[62:0]};
    c = {1'b0, cs[62:0]};
    case (quad)
      2'd0: begin so = s;  co = c;  end
      2'd1: begin so = c;  co = -s; end
      2'd2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
  endtask

  task automatic eop_series(longint t, int ep, int off, int rate, int h0, int nh,
                            inout bit perr, output logic [OUT_W-1:0] res);
    longint dt, acc, per, s, c;
    int h;
    dt = sub_sat(t, coef_table[ep]);
    acc = coef_table[off];
    acc = add_sat(acc, fix_mul(coef_table[rate], dt, FRAC_BITS));
    for (h = h0; h < h0 + nh; h++) begin
      per = coef_table[SLOT_PERIOD + h];
      if (per == 0) begin
        perr = 1'b1;
      end else begin
        sine_cosine(phase_turns(dt, per), s, c);
        acc = add_sat(acc, add_sat(fix_mul(coef_table[SLOT_AMP + 2 * h], s, 62),
                                   fix_mul(coef_table[SLOT_AMP + 2 * h + 1], c, 62)));
      end
    end
    if (acc > O48_MAX) acc = O48_MAX;
    if (acc < O48_MIN) acc = O48_MIN;
    res = acc[OUT_W-1:0];
  endtask

  task automatic predict_eop(logic [TIME_W-1:0] tm);
    eop_t e;
    bit perr;
    longint t;
    perr = 1'b0;
    t = longint'({15'b0, tm});
    eop_series(t, SLOT_EPOCH_XY, SLOT_OFFSET,     SLOT_RATE,     0, 2, perr, e.px);
    eop_series(t, SLOT_EPOCH_XY, SLOT_OFFSET + 1, SLOT_RATE + 1, 2, 2, perr, e.py);
    eop_series(t, SLOT_EPOCH_UT, SLOT_OFFSET + 2, SLOT_RATE + 2, 4, 4, perr, e.ut);
    e.perr = perr;
    expected_eop.push_back(e);
  endtask

  // driver and input-side prediction
  always @(posedge clk) begin
    req_t r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (req_type == REQ_LOAD) coef_table[coef_index] = coef_value;
        else predict_eop(eval_time);
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() == 0 || $urandom_range(99) < sender_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.req_type;
          coef_index <= r.coef_index;
          coef_value <= r.coef_value;
          eval_time <= r.eval_time;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    eop_t e;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_eop.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_eop.pop_front();
          if (polar_x !== e.px) begin
            $error("polar_x exp %h got %h", e.px, polar_x); errors++;
          end
          if (polar_y !== e.py) begin
            $error("polar_y exp %h got %h", e.py, polar_y); errors++;
          end
          if (ut1_minus_utc !== e.ut) begin
            $error("ut1_minus_utc exp %h got %h", e.ut, ut1_minus_utc); errors++;
          end
          if (period_error !== e.perr) begin
            $error("period_error exp %b got %b", e.perr, period_error); errors++;
          end
        end
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_load(int idx, logic [63:0] v);
    req_t r;
    r.req_type = REQ_LOAD;
    r.coef_index = IDX_W'(idx);
    r.coef_value = v;
    r.eval_time = TIME_W'(rnd64());
    pending_reqs.push_back(r);
  endtask

  task automatic push_eval(logic [TIME_W-1:0] tm);
    req_t r;
    r.req_type = REQ_EVAL;
    r.coef_index = IDX_W'($urandom);
    r.coef_value = rnd64();
    r.eval_time = tm;
    pending_reqs.push_back(r);
  endtask

  // coefficient value shaped for the slot, with some extremes and raw noise
  function automatic logic [63:0] coef_for(int idx);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return rnd64();
    if (pick < 12) return pick[0] ? I64_MAX : I64_MIN;
    if (idx < SLOT_OFFSET) return MJD_NOW + longint'($signed({$urandom_range(255), 32'h0}))
                                  + $urandom;
    if (idx >= SLOT_PERIOD) begin
      if (pick < 20) return '0;
      if (pick < 30) return -((longint'($urandom_range(500, 1)) << 32) + $urandom);
      return (longint'($urandom_range(500, 1)) << 32) + $urandom;
    end
    return longint'($signed($urandom)) <<< $urandom_range(4, 0);
  endfunction

  function automatic logic [TIME_W-1:0] time_pick();
    if ($urandom_range(9) < 2) return TIME_W'(rnd64());
    return TIME_W'(MJD_NOW + (longint'($urandom_range(2000)) << 32) + $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_eop.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int idle, int stall, int n);
    int idx;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(31);
      if ($urandom_range(99) < 7) push_eval(time_pick());
      else push_load(idx, coef_for(idx));
    end
    push_eval(time_pick());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // every slot written before the first evaluation
    push_load(SLOT_EPOCH_XY, MJD_NOW);
    push_load(SLOT_EPOCH_UT, MJD_NOW + (64'd12 << 32));
    for (int i = SLOT_OFFSET; i < SLOT_PERIOD; i++)
      push_load(i, longint'($signed($urandom)));
    push_load(SLOT_PERIOD,     64'd365 << 32);
    push_load(SLOT_PERIOD + 1, 64'd433 << 32);
    for (int i = SLOT_PERIOD + 2; i < 32; i++)
      push_load(i, (longint'($urandom_range(400, 10)) << 32) + $urandom);
    push_eval(MJD_NOW);
    push_eval('0);
    push_eval({TIME_W{1'b1}});
    // extremes: saturating rate, full-scale amplitudes, negative and zero periods, extreme UT epochs
    push_load(SLOT_RATE, I64_MAX);
    push_load(SLOT_AMP, I64_MIN);
    push_load(SLOT_AMP + 9, I64_MAX);
    push_load(SLOT_PERIOD + 2, -(64'd27 << 32));
    push_load(SLOT_PERIOD + 6, '0);
    push_load(SLOT_EPOCH_UT, I64_MIN);
    push_eval(MJD_NOW + (64'd100 << 32) + 64'h8000_0000);
    push_load(SLOT_EPOCH_UT, I64_MAX);
    push_load(SLOT_PERIOD + 3, 64'd1);
    push_eval({TIME_W{1'b1}});
    wait_drained();
    random_phase(0, 0, 135);
    random_phase(67, 0, 135);
    random_phase(0, 67, 135);
    random_phase(13, 13, 135);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("earth_orientation_harmonic_predictor_core: match");
    else $display("earth_orientation_harmonic_predictor_core: mismatch");
    $finish;
  end

  initial begin
    #1s;
    $display("earth_orientation_harmonic_predictor_core: mismatch");
    $finish;
  end

endmodule

>>> sim.f
rtl/eohp_pkg.sv
rtl/eohp_ram.sv
rtl/eohp_ctrl.sv
rtl/eohp_dp.sv
rtl/earth_orientation_harmonic_predictor_core.sv
rtl/eohp_chk.sv
tb/tb_earth_orientation_harmonic_predictor_core.sv
